FILE: hdl/move_to_front_key_list_assert.svh
// Assertion macros for the move-to-front key list.
// Used by move_to_front_key_list.sv; expects signals named clock and reset in scope.
`ifndef MOVE_TO_FRONT_KEY_LIST_ASSERT_SVH
`define MOVE_TO_FRONT_KEY_LIST_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MTFKL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define MTFKL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/mtfkl_pkg.sv
// Shared types and codes for the move-to-front key list.
// No dependencies; imported by mtfkl_key_ram and move_to_front_key_list.
package mtfkl_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_MOVE   = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_DN,
      ST_SHIFT_UP,
      ST_FRONT
   } state_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [3:0] position;
      logic [4:0] entry_count;
   } rsp_type;

endpackage

FILE: hdl/mtfkl_key_ram.sv
// Key storage: one write port, one read port with registered read data.
// Depends on mtfkl_pkg.
module mtfkl_key_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import mtfkl_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/move_to_front_key_list.sv
// Move-to-front key list: sequencer, control registers and result register.
// Depends on mtfkl_pkg, mtfkl_key_ram and move_to_front_key_list_assert.svh.
//
// Usage
//   Request: drive req_item (op, key) and raise start; the transaction is taken
//   at the rising edge where start is high and busy is low. busy stays high
//   while the sequencer walks the key memory.
//   Result: rsp_valid pulses for one cycle with rsp_item (status, position,
//   entry_count). The receiver cannot stall; it must take the result then.
// Steps, from the accept edge to the result strobe (p = matched position):
//   refused insert into a full list, or any lookup in an empty list: none
//   insert: shift walk plus front write, only the front write if list empty
//   search: scan from the front to the first hit, or to the last entry on a miss
//   search and move: adds the shift and front write (none when p is 0);
//   delete adds the close-up, none for the last entry
// The walk reads one entry per cycle through the single read port, and read
// data is registered; busy drops in the cycle the result strobe is shown.
// Reset clears the entry count and the sequencer; key storage is not cleared,
// since only entries below the count are ever read.
module move_to_front_key_list #(
   parameter int LIST_DEPTH = 16,
   parameter int KEY_BITS   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mtfkl_pkg::req_type req_item,
   output logic               rsp_valid,
   output mtfkl_pkg::rsp_type rsp_item
);
   import mtfkl_pkg::*;

`include "move_to_front_key_list_assert.svh"

   localparam int IDX_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);

   state_type             state_ff,  state_in;
   op_type                op_ff,     op_in;
   logic [KEY_BITS-1:0]   key_ff,    key_in;
   logic [CNT_BITS-1:0]   count_ff,  count_in;
   logic [IDX_BITS-1:0]   ptr_ff,    ptr_in;
   logic [IDX_BITS-1:0]   pos_ff,    pos_in;
   logic                  issue_ff,  issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_BITS-1:0]   rd_idx_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_item_ff,  rsp_item_in;

   logic [KEY_BITS-1:0]   rd_data;
   logic                  mem_we;
   logic [IDX_BITS-1:0]   mem_wa;
   logic [KEY_BITS-1:0]   mem_wd;
   logic [IDX_BITS-1:0]   last_idx;
   logic                  finish;
   status_type            fin_status;
   logic [IDX_BITS-1:0]   fin_pos;

   assign last_idx = IDX_BITS'(count_ff - CNT_BITS'(1));

   mtfkl_key_ram #(
      .DEPTH (LIST_DEPTH),
      .WIDTH (KEY_BITS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (rd_vld_in),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      ptr_ff      <= ptr_in;
      pos_ff      <= pos_in;
      rd_idx_ff   <= ptr_ff;
      rsp_item_ff <= rsp_item_in;
   end

   // sequencer: next state, memory port and result
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      pos_in     = pos_ff;
      issue_in   = issue_ff;
      rd_vld_in  = 1'b0;
      mem_we     = 1'b0;
      mem_wa     = '0;
      mem_wd     = key_ff;
      finish     = 1'b0;
      fin_status = STAT_OK;
      fin_pos    = '0;

      case (state_ff)
         ST_IDLE: begin
            issue_in = 1'b0;
            if (start) begin
               op_in  = req_item.op;
               key_in = KEY_BITS'(req_item.key);
               if (req_item.op == OP_INSERT) begin
                  if (count_ff == CNT_BITS'(LIST_DEPTH)) begin
                     finish     = 1'b1;
                     fin_status = STAT_FULL;
                  end else if (count_ff == '0) begin
                     state_in = ST_FRONT;
                  end else begin
                     state_in = ST_SHIFT_DN;
                     ptr_in   = last_idx;
                     issue_in = 1'b1;
                  end
               end else if (count_ff == '0) begin
                  finish     = 1'b1;
                  fin_status = STAT_NOT_FOUND;
               end else begin
                  state_in = ST_SCAN;
                  ptr_in   = '0;
                  issue_in = 1'b1;
               end
            end
         end

         // walk from the front, compare one entry per cycle
         ST_SCAN: begin
            rd_vld_in = issue_ff;
            if (issue_ff) begin
               if (ptr_ff == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + IDX_BITS'(1);
               end
            end
            if (rd_vld_ff) begin
               if (rd_data == key_ff) begin
                  pos_in    = rd_idx_ff;
                  rd_vld_in = 1'b0;
                  issue_in  = 1'b0;
                  case (op_ff)
                     OP_MOVE: begin
                        if (rd_idx_ff == '0) begin
                           finish = 1'b1;
                        end else begin
                           state_in = ST_SHIFT_DN;
                           ptr_in   = rd_idx_ff - IDX_BITS'(1);
                           issue_in = 1'b1;
                        end
                     end
                     OP_DELETE: begin
                        if (rd_idx_ff == last_idx) begin
                           finish   = 1'b1;
                           count_in = count_ff - CNT_BITS'(1);
                        end else begin
                           state_in = ST_SHIFT_UP;
                           ptr_in   = rd_idx_ff + IDX_BITS'(1);
                           issue_in = 1'b1;
                        end
                     end
                     default: begin
                        finish = 1'b1;
                     end
                  endcase
                  fin_pos = rd_idx_ff;
               end else if (rd_idx_ff == last_idx) begin
                  rd_vld_in  = 1'b0;
                  issue_in   = 1'b0;
                  finish     = 1'b1;
                  fin_status = STAT_NOT_FOUND;
               end
            end
         end

         // push entries one place toward the back, walking down to entry 0
         ST_SHIFT_DN: begin
            rd_vld_in = issue_ff;
            if (issue_ff) begin
               if (ptr_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - IDX_BITS'(1);
               end
            end
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               mem_wa = rd_idx_ff + IDX_BITS'(1);
               mem_wd = rd_data;
               if (rd_idx_ff == '0) begin
                  state_in  = ST_FRONT;
                  rd_vld_in = 1'b0;
               end
            end
         end

         // close the gap after a delete, walking up to the last entry
         ST_SHIFT_UP: begin
            rd_vld_in = issue_ff;
            if (issue_ff) begin
               if (ptr_ff == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + IDX_BITS'(1);
               end
            end
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               mem_wa = rd_idx_ff - IDX_BITS'(1);
               mem_wd = rd_data;
               if (rd_idx_ff == last_idx) begin
                  rd_vld_in = 1'b0;
                  issue_in  = 1'b0;
                  finish    = 1'b1;
                  fin_pos   = pos_ff;
                  count_in  = count_ff - CNT_BITS'(1);
               end
            end
         end

         // write the key at the front
         ST_FRONT: begin
            mem_we = 1'b1;
            mem_wa = '0;
            mem_wd = key_ff;
            finish = 1'b1;
            if (op_ff == OP_INSERT) begin
               count_in = count_ff + CNT_BITS'(1);
            end else begin
               fin_pos = pos_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
            issue_in = 1'b0;
         end
      endcase

      if (finish) begin
         state_in = ST_IDLE;
      end
      rsp_valid_in             = finish;
      rsp_item_in.status       = fin_status;
      rsp_item_in.position     = 4'(fin_pos);
      rsp_item_in.entry_count  = 5'(count_in);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // checks
   `MTFKL_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_BITS'(LIST_DEPTH), "entry count overflow")
   `MTFKL_ASSERT_NEXT(a_accept_progress, start && !busy, rsp_valid || busy, "transaction dropped")
   `MTFKL_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result shown while sequencer busy")
   `MTFKL_ASSERT_NOW(a_full_count, rsp_valid && rsp_item.status == STAT_FULL, rsp_item.entry_count == 5'(LIST_DEPTH), "full status with room left")
   `MTFKL_ASSERT_NOW(a_write_busy, mem_we, busy, "key write outside a transaction")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for move_to_front_key_list: directed and random list operations.
// Depends on mtfkl_pkg and the move_to_front_key_list RTL.
// Each result is checked against a local model of the key list.
module testbench;
   import mtfkl_pkg::*;

   localparam int DEPTH          = 16;
   localparam int RANDOM_ITEMS   = 1275;
   localparam int PHASE_LEN      = 160;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 80;
   localparam int REPORT_LIMIT   = 10;

   // One queued request, with its sender idle rate and an optional drain hold
   typedef struct {
      req_type     req;
      int unsigned idle_pct;
      bit          drain_first;
   } pending_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_valid;
   req_type req_item;
   rsp_type rsp_item;

   pending_type pend_q[$];
   rsp_type     expected_q[$];

   // Model of the list, front entry at index 0
   logic [31:0] model_keys [DEPTH];
   int unsigned model_count;

   int unsigned mismatches;
   int unsigned watchdog_count;
   bit          taken;
   bit          timed_out;

   move_to_front_key_list dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the model list and return the result it gives
   function automatic rsp_type apply_list_op(req_type r);
      rsp_type res;
      int      hit;
      res.status   = STAT_OK;
      res.position = '0;
      if (r.op == OP_INSERT) begin
         if (model_count >= DEPTH) begin
            res.status = STAT_FULL;
         end else begin
            for (int i = model_count; i > 0; i--) model_keys[i] = model_keys[i-1];
            model_keys[0] = r.key;
            model_count++;
         end
      end else begin
         // first match from the front
         hit = -1;
         for (int i = 0; i < model_count; i++)
            if (hit < 0 && model_keys[i] == r.key) hit = i;
         if (hit < 0) begin
            res.status = STAT_NOT_FOUND;
         end else begin
            res.position = hit[3:0];
            if (r.op == OP_MOVE) begin
               for (int i = hit; i > 0; i--) model_keys[i] = model_keys[i-1];
               model_keys[0] = r.key;
            end else if (r.op == OP_DELETE) begin
               for (int i = hit; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
               model_count--;
            end
         end
      end
      res.entry_count = model_count[4:0];
      return res;
   endfunction

   task automatic add_item(op_type op, logic [31:0] key, int unsigned idle, bit drain);
      pending_type p;
      p.req.op      = op;
      p.req.key     = key;
      p.idle_pct    = idle;
      p.drain_first = drain;
      pend_q.push_back(p);
   endtask

   // Driver: a new transaction is offered only once the previous one was taken
   always @(negedge clock) begin
      if (!reset && (!start || taken)) begin
         if (pend_q.size() == 0) begin
            start <= 1'b0;
         end else if (pend_q[0].drain_first && expected_q.size() != 0) begin
            start <= 1'b0;
         end else if ($urandom_range(99) < pend_q[0].idle_pct) begin
            start <= 1'b0;
         end else begin
            req_item <= pend_q[0].req;
            start    <= 1'b1;
            void'(pend_q.pop_front());
         end
      end
   end

   // Monitor: check results first, then log the newly accepted request
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         taken          <= 1'b0;
         watchdog_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result: status %0d pos %0d count %0d",
                           rsp_item.status, rsp_item.position, rsp_item.entry_count);
            end else begin
               want = expected_q.pop_front();
               if (rsp_item.status !== want.status || rsp_item.position !== want.position ||
                   rsp_item.entry_count !== want.entry_count) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("mismatch: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                              want.status, want.position, want.entry_count,
                              rsp_item.status, rsp_item.position, rsp_item.entry_count);
               end
            end
         end
         if (start && !busy) expected_q.push_back(apply_list_op(req_item));
         taken          <= start && !busy;
         watchdog_count <= (rsp_valid || (start && !busy)) ? 0 : watchdog_count + 1;
      end
   end

   initial begin
      logic [31:0] key_pool [10];
      int unsigned phase_idle [8];
      op_type      op;
      logic [31:0] k;
      int unsigned w;
      int unsigned mode;

      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      model_count = 0;
      mismatches  = 0;
      timed_out   = 1'b0;

      // Empty list: every lookup misses
      add_item(OP_SEARCH, 32'd5, 0, 1'b0);
      add_item(OP_MOVE,   32'd5, 0, 1'b0);
      add_item(OP_DELETE, 32'd5, 0, 1'b0);
      // Key extremes
      add_item(OP_INSERT, 32'h7fff_ffff, 0, 1'b0);
      add_item(OP_INSERT, 32'h8000_0000, 0, 1'b0);
      add_item(OP_INSERT, 32'h0000_0000, 0, 1'b0);
      add_item(OP_INSERT, 32'hffff_ffff, 0, 1'b0);
      add_item(OP_SEARCH, 32'h8000_0000, 0, 1'b0);
      // move from the back, then move of the front entry
      add_item(OP_MOVE,   32'h7fff_ffff, 0, 1'b0);
      add_item(OP_MOVE,   32'h7fff_ffff, 0, 1'b0);
      add_item(OP_SEARCH, 32'd12345, 0, 1'b0);
      // Fill to capacity, with a duplicate of zero among the fill
      for (int i = 0; i < 12; i++) add_item(OP_INSERT, i, 0, 1'b0);
      add_item(OP_INSERT, 32'hdead_beef, 0, 1'b0);
      add_item(OP_DELETE, 32'h0000_0000, 0, 1'b0);
      add_item(OP_DELETE, 32'h8000_0000, 0, 1'b0);
      add_item(OP_SEARCH, 32'h0000_0000, 0, 1'b0);

      // Random part: small key pool for hits, phases of sender idling
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hffff_ffff;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7fff_ffff;
      for (int i = 4; i < 10; i++) key_pool[i] = $urandom;
      phase_idle = '{0, 78, 0, 36, 78, 0, 36, 78};
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         mode = (n / 40) % 3;
         w    = $urandom_range(99);
         case (mode)
            0: begin // mostly inserts, drives the list to full
               if (w < 55)      op = OP_INSERT;
               else if (w < 70) op = OP_SEARCH;
               else if (w < 85) op = OP_MOVE;
               else             op = OP_DELETE;
            end
            1: begin // mostly deletes, drives the list to empty
               if (w < 15)      op = OP_INSERT;
               else if (w < 35) op = OP_SEARCH;
               else if (w < 50) op = OP_MOVE;
               else             op = OP_DELETE;
            end
            default: begin
               if (w < 25)      op = OP_INSERT;
               else if (w < 50) op = OP_SEARCH;
               else if (w < 75) op = OP_MOVE;
               else             op = OP_DELETE;
            end
         endcase
         k = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(9)];
         add_item(op, k, phase_idle[n / PHASE_LEN], (n == 0) || (n == 640));
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fork
         begin
            wait (pend_q.size() == 0 && !start);
            wait (expected_q.size() == 0);
            repeat (TAIL_CYCLES) @(posedge clock);
         end
         begin
            wait (watchdog_count >= WATCHDOG_LIMIT);
            timed_out = 1'b1;
         end
      join_any

      if (!timed_out && mismatches == 0 && expected_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
